// ===== rtl/tgr_pkg.sv =====
package tgr_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int TIMER_BITS = 16;
    localparam int ELAPSED_BITS = 12;

    localparam logic [4:0] TILT_X  = 5'b10000;
    localparam logic [4:0] TILT_Y  = 5'b01000;
    localparam logic [4:0] TILT_Z  = 5'b00100;
    localparam logic [4:0] TILT_HI = 5'b00010;
    localparam logic [4:0] TILT_LO = 5'b00001;
    localparam logic [4:0] TILT_NONE = 5'b00000;

    localparam logic [1:0] STAGE_FIRST  = 2'd1;
    localparam logic [1:0] STAGE_SECOND = 2'd2;

    localparam logic [1:0] CFG_TILT_HIGH  = 2'd0;
    localparam logic [1:0] CFG_TILT_LOW   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_MS = 2'd2;

    localparam logic [2:0] GESTURE_UP_LEFT    = 3'd0;
    localparam logic [2:0] GESTURE_UP_RIGHT   = 3'd1;
    localparam logic [2:0] GESTURE_DOWN_LEFT  = 3'd2;
    localparam logic [2:0] GESTURE_DOWN_RIGHT = 3'd3;
    localparam logic [2:0] GESTURE_RIGHT_UP   = 3'd4;
    localparam logic [2:0] GESTURE_RIGHT_DOWN = 3'd5;
    localparam logic [2:0] GESTURE_LEFT_UP    = 3'd6;
    localparam logic [2:0] GESTURE_LEFT_DOWN  = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [ELAPSED_BITS-1:0]       elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] gesture_index;
        logic       timed_out;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] tilt_high;
        logic signed [SAMPLE_BITS-1:0] tilt_low;
        logic [TIMER_BITS-1:0]         timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            stage;
        logic [4:0]            first_tilt;
        logic [TIMER_BITS-1:0] elapsed_total;
    } t_state;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

// ===== rtl/two_stage_tilt_gesture_recognizer.sv =====
// Two-stage tilt gesture recognizer. Each sample transaction carries a 3-axis
// accelerometer reading and the milliseconds since the previous sample; the
// block finds a first tilt, then a matching second tilt, and returns a gesture
// index 0..7, or a timeout when the timer, cleared by a result or a first tilt,
// passes timeout_ms. Takes one sample every cycle unless a stalled result holds
// it back; a sample's result (if any) is set into the result register from the
// input register through the combinational compare-and-select step. Write
// configuration only while no sample is in flight.
module two_stage_tilt_gesture_recognizer
    import tgr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [TIMER_BITS-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_result   n_result;
    logic      w_advance;
    logic      w_fire;

    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_fire = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    assign o_cfg_ready = 1'b1;

    tgr_step u_step (
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg.tilt_high <= SAMPLE_BITS'(10);
            r_cfg.tilt_low <= -SAMPLE_BITS'(10);
            r_cfg.timeout_ms <= TIMER_BITS'(3000);
            r_state.stage <= STAGE_FIRST;
            r_state.first_tilt <= TILT_NONE;
            r_state.elapsed_total <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
                r_in_data <= i_in_data;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_state <= n_state;
                r_out_valid <= n_result.valid;
                r_out_data <= n_result.item;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TILT_HIGH:  r_cfg.tilt_high <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_TILT_LOW:   r_cfg.tilt_low <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_TIMEOUT_MS: r_cfg.timeout_ms <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_stage_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stage == STAGE_FIRST || r_state.stage == STAGE_SECOND)
        else $error("stage left its legal codes");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_result.valid) |=>
            (r_state.stage == STAGE_FIRST && r_state.elapsed_total == '0
             && r_state.first_tilt == TILT_NONE))
        else $error("result did not clear the sequence");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room to advance");

    a_timeout_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_result.valid && n_result.item.timed_out) |=>
            (o_out_valid && o_out_data.gesture_index == GESTURE_UP_LEFT))
        else $error("timeout transaction carries a gesture index");
`endif

endmodule

// ===== rtl/tgr_step.sv =====
module tgr_step
    import tgr_pkg::*;
(
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    input  t_state   i_state,
    output t_state   o_state,
    output t_result  o_result
);

    logic [TIMER_BITS:0]   w_sum;
    logic [TIMER_BITS-1:0] w_timer;
    logic                  x_hi, x_lo, y_hi, y_lo, z_hi, z_lo;
    logic [4:0]            w_first;
    logic [1:0]            w_stage;
    logic                  w_match;
    logic [2:0]            w_index;

    assign w_sum = {1'b0, i_state.elapsed_total}
                 + {{(TIMER_BITS + 1 - ELAPSED_BITS){1'b0}}, i_item.elapsed_ms};
    assign w_timer = w_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : w_sum[TIMER_BITS-1:0];

    assign x_hi = i_item.accel_x > i_cfg.tilt_high;
    assign x_lo = i_item.accel_x < i_cfg.tilt_low;
    assign y_hi = i_item.accel_y > i_cfg.tilt_high;
    assign y_lo = i_item.accel_y < i_cfg.tilt_low;
    assign z_hi = i_item.accel_z > i_cfg.tilt_high;
    assign z_lo = i_item.accel_z < i_cfg.tilt_low;

    always_comb begin
        w_first = i_state.first_tilt;
        w_stage = i_state.stage;
        w_match = 1'b0;
        w_index = GESTURE_UP_LEFT;

        // first tilt, priority x, y, z and high before low
        if (i_state.stage == STAGE_FIRST) begin
            if (x_hi || x_lo || y_hi || y_lo || z_hi || z_lo) begin
                w_stage = STAGE_SECOND;
            end
            if (x_hi) begin
                w_first = TILT_X | TILT_HI;
            end else if (x_lo) begin
                w_first = TILT_X | TILT_LO;
            end else if (y_hi) begin
                w_first = TILT_Y | TILT_HI;
            end else if (y_lo) begin
                w_first = TILT_Y | TILT_LO;
            end else if (z_hi) begin
                w_first = TILT_Z | TILT_HI;
            end else if (z_lo) begin
                w_first = TILT_Z | TILT_LO;
            end
        end

        // second tilt, may complete on the same sample
        if (w_stage == STAGE_SECOND) begin
            case (w_first)
                TILT_Z | TILT_LO: begin
                    w_match = y_hi || y_lo;
                    w_index = y_hi ? GESTURE_UP_LEFT : GESTURE_UP_RIGHT;
                end
                TILT_Z | TILT_HI: begin
                    w_match = y_hi || y_lo;
                    w_index = y_hi ? GESTURE_DOWN_LEFT : GESTURE_DOWN_RIGHT;
                end
                TILT_Y | TILT_LO: begin
                    w_match = z_lo || z_hi;
                    w_index = z_lo ? GESTURE_RIGHT_UP : GESTURE_RIGHT_DOWN;
                end
                TILT_Y | TILT_HI: begin
                    w_match = z_lo || z_hi;
                    w_index = z_lo ? GESTURE_LEFT_UP : GESTURE_LEFT_DOWN;
                end
                default: begin
                    w_match = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        o_state.elapsed_total = w_timer;
        o_result.valid = 1'b0;
        o_result.item.gesture_index = GESTURE_UP_LEFT;
        o_result.item.timed_out = 1'b0;

        if (w_timer > i_cfg.timeout_ms) begin
            o_state.stage = STAGE_FIRST;
            o_state.first_tilt = TILT_NONE;
            o_state.elapsed_total = '0;
            o_result.valid = 1'b1;
            o_result.item.timed_out = 1'b1;
        end else if (w_timer != i_cfg.timeout_ms) begin
            if (w_match) begin
                o_state.stage = STAGE_FIRST;
                o_state.first_tilt = TILT_NONE;
                o_state.elapsed_total = '0;
                o_result.valid = 1'b1;
                o_result.item.gesture_index = w_index;
            end else begin
                o_state.stage = w_stage;
                o_state.first_tilt = w_first;
                if (i_state.stage == STAGE_FIRST && w_stage == STAGE_SECOND) begin
                    o_state.elapsed_total = '0;
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top
    import tgr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int AX_NEUTRAL = 0;
    localparam int AX_HIGH    = 1;
    localparam int AX_LOW     = 2;
    localparam int AX_ANY     = 3;
    localparam logic [7:0] STALL_PATTERN = 8'b0110_1001;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = CFG_TILT_HIGH;
    logic [TIMER_BITS-1:0] i_cfg_data  = '0;

    // predictor copy of the block's registers and state
    logic signed [SAMPLE_BITS-1:0] cfg_high    = 8'sd10;
    logic signed [SAMPLE_BITS-1:0] cfg_low     = -8'sd10;
    logic [TIMER_BITS-1:0]         cfg_timeout = 16'd3000;
    logic [1:0]                    stage       = STAGE_FIRST;
    logic [4:0]                    first_tilt  = TILT_NONE;
    logic [TIMER_BITS-1:0]         ms_timer    = '0;

    t_in_item  samples_to_send[$];
    t_out_item gestures_due[$];

    bit sample_taken = 1'b0;
    bit steady_send  = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left = 0;
    int rx_cycle = 0;

    int n_errors = 0;
    int n_samples = 0;
    int n_queued = 0;
    int n_timeouts = 0;
    int n_reg_writes = 0;
    int n_settings = 0;
    int n_backpressure = 0;
    int gesture_hits[8];

    two_stage_tilt_gesture_recognizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic recognize_sample(input t_in_item s);
        logic signed [SAMPLE_BITS-1:0] ax, ay, az;
        logic [TIMER_BITS:0] sum;
        logic [4:0] tilt;
        t_out_item res;
        bit hit;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        sum = {1'b0, ms_timer} + {5'b0, s.elapsed_ms};
        ms_timer = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
        hit = 1'b0;
        res = '0;
        if (ms_timer > cfg_timeout) begin
            hit = 1'b1;
            res.timed_out = 1'b1;
            n_timeouts++;
        end else if (ms_timer < cfg_timeout) begin
            if (stage == STAGE_FIRST) begin
                tilt = TILT_NONE;
                if (ax > cfg_high)      tilt = TILT_X | TILT_HI;
                else if (ax < cfg_low)  tilt = TILT_X | TILT_LO;
                else if (ay > cfg_high) tilt = TILT_Y | TILT_HI;
                else if (ay < cfg_low)  tilt = TILT_Y | TILT_LO;
                else if (az > cfg_high) tilt = TILT_Z | TILT_HI;
                else if (az < cfg_low)  tilt = TILT_Z | TILT_LO;
                if (tilt != TILT_NONE) begin
                    first_tilt = tilt;
                    ms_timer = '0;
                    stage = STAGE_SECOND;
                end
            end
            if (stage == STAGE_SECOND) begin
                case (first_tilt)
                    TILT_Z | TILT_LO: begin
                        if (ay > cfg_high) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_UP_LEFT;
                        end else if (ay < cfg_low) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_UP_RIGHT;
                        end
                    end
                    TILT_Z | TILT_HI: begin
                        if (ay > cfg_high) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_DOWN_LEFT;
                        end else if (ay < cfg_low) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_DOWN_RIGHT;
                        end
                    end
                    TILT_Y | TILT_LO: begin
                        if (az < cfg_low) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_RIGHT_UP;
                        end else if (az > cfg_high) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_RIGHT_DOWN;
                        end
                    end
                    TILT_Y | TILT_HI: begin
                        if (az < cfg_low) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_LEFT_UP;
                        end else if (az > cfg_high) begin
                            hit = 1'b1;
                            res.gesture_index = GESTURE_LEFT_DOWN;
                        end
                    end
                    default: ;
                endcase
                if (hit) gesture_hits[res.gesture_index]++;
            end
        end
        if (hit) begin
            stage = STAGE_FIRST;
            first_tilt = TILT_NONE;
            ms_timer = '0;
            gestures_due.push_back(res);
        end
    endtask

    // monitor: config writes, results and accepted samples
    always @(posedge i_clk) begin
        t_out_item want;
        sample_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TILT_HIGH:  cfg_high = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_TILT_LOW:   cfg_low = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_TIMEOUT_MS: cfg_timeout = i_cfg_data;
                    default: ;
                endcase
                n_reg_writes++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (gestures_due.size() == 0) begin
                    report_mismatch($sformatf("result idx=%0d to=%0b with nothing expected",
                        o_out_data.gesture_index, o_out_data.timed_out));
                end else begin
                    want = gestures_due.pop_front();
                    if (o_out_data.gesture_index !== want.gesture_index)
                        report_mismatch($sformatf("gesture_index got %0d want %0d",
                            o_out_data.gesture_index, want.gesture_index));
                    if (o_out_data.timed_out !== want.timed_out)
                        report_mismatch($sformatf("timed_out got %0b want %0b",
                            o_out_data.timed_out, want.timed_out));
                end
            end
            if (i_in_valid && o_in_stall) n_backpressure++;
            if (i_in_valid && !o_in_stall) begin
                sample_taken = 1'b1;
                n_samples++;
                recognize_sample(i_in_data);
            end
        end
    end

    // sample driver: bursts with random gaps, no gaps while steady_send is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || sample_taken) begin
            if (gap_left > 0 && !steady_send) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
                i_in_data <= samples_to_send.pop_front();
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: own stall pattern plus long holds on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_started != hold_requests) begin
                holds_started++;
                hold_left = 119;
                i_out_stall <= 1'b1;
            end else begin
                case ((rx_cycle / 160) % 4)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(2, 0) == 0);
                    2: i_out_stall <= STALL_PATTERN[rx_cycle % 8];
                    default: i_out_stall <= ($urandom_range(2, 0) != 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] axis_value(input int kind);
        int h, l, v;
        h = cfg_high;
        l = cfg_low;
        v = $urandom_range(255, 0) - 128;
        case (kind)
            AX_HIGH:    if (h < 127) v = $urandom_range(255, h + 129) - 128;
            AX_LOW:     if (l > -128) v = $urandom_range(l + 127, 0) - 128;
            AX_NEUTRAL: if (l <= h) v = $urandom_range(h + 128, l + 128) - 128;
            default: ;
        endcase
        return v[7:0];
    endfunction

    function automatic logic [ELAPSED_BITS-1:0] pick_ms();
        int r, cap, v;
        r = $urandom_range(9, 0);
        cap = cfg_timeout / 3 + 1;
        if (cap > 4095) cap = 4095;
        if (r < 6)      v = $urandom_range(cap, 0);
        else if (r < 8) v = $urandom_range(4095, 0);
        else if (r == 8) v = 0;
        else            v = 4095;
        return v[ELAPSED_BITS-1:0];
    endfunction

    function automatic t_in_item make_sample(input int kx, input int ky, input int kz);
        t_in_item s;
        s.accel_x = axis_value(kx);
        s.accel_y = axis_value(ky);
        s.accel_z = axis_value(kz);
        s.elapsed_ms = pick_ms();
        return s;
    endfunction

    function automatic t_in_item fixed_sample(input int x, input int y, input int z,
                                              input int ms);
        t_in_item s;
        s.accel_x = x[7:0];
        s.accel_y = y[7:0];
        s.accel_z = z[7:0];
        s.elapsed_ms = ms[ELAPSED_BITS-1:0];
        return s;
    endfunction

    function automatic int rand_kind();
        return $urandom_range(2, 0);
    endfunction

    function automatic int mostly_neutral();
        return ($urandom_range(3, 0) == 0) ? rand_kind() : AX_NEUTRAL;
    endfunction

    task automatic queue_sample(input t_in_item s);
        samples_to_send.push_back(s);
        n_queued++;
    endtask

    // first tilt, up to two in-between samples, then a second tilt that matches unless the first was an x tilt
    task automatic add_gesture_seq();
        int first, n_mid, kx, ky, kz, tilt_kind;
        first = $urandom_range(9, 0);
        kx = AX_NEUTRAL;
        ky = AX_NEUTRAL;
        kz = rand_kind();
        if (first < 4) begin
            kz = (first < 2) ? AX_LOW : AX_HIGH;
        end else if (first < 8) begin
            ky = (first < 6) ? AX_LOW : AX_HIGH;
        end else begin
            kx = (first == 8) ? AX_HIGH : AX_LOW;
            ky = rand_kind();
        end
        queue_sample(make_sample(kx, ky, kz));
        n_mid = $urandom_range(2, 0);
        repeat (n_mid) queue_sample(make_sample(mostly_neutral(), mostly_neutral(),
                                                mostly_neutral()));
        tilt_kind = ($urandom_range(1, 0) == 0) ? AX_HIGH : AX_LOW;
        if (first < 4)
            queue_sample(make_sample(rand_kind(), tilt_kind, rand_kind()));
        else if (first < 8)
            queue_sample(make_sample(rand_kind(), rand_kind(), tilt_kind));
        else
            queue_sample(make_sample(rand_kind(), rand_kind(), rand_kind()));
    endtask

    task automatic add_random_items(input int n);
        int target, r;
        target = n_queued + n;
        while (n_queued < target) begin
            r = $urandom_range(9, 0);
            if (r < 7)
                add_gesture_seq();
            else if (r < 9)
                queue_sample(make_sample(AX_ANY, AX_ANY, AX_ANY));
            else
                queue_sample(make_sample(AX_NEUTRAL, AX_NEUTRAL, AX_NEUTRAL));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TIMER_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((samples_to_send.size() != 0 || i_in_valid || gestures_due.size() != 0)
               && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int hi, input int lo, input int to, input int n,
                             input bit pressure);
        logic [7:0] junk;
        junk = $urandom_range(255, 0);
        write_reg(CFG_TILT_HIGH, {junk, hi[7:0]});
        junk = $urandom_range(255, 0);
        write_reg(CFG_TILT_LOW, {junk, lo[7:0]});
        write_reg(CFG_TIMEOUT_MS, to[TIMER_BITS-1:0]);
        n_settings++;
        if (pressure) begin
            steady_send = 1'b1;
            hold_requests++;
        end
        add_random_items(n);
        wait_drained();
        steady_send = 1'b0;
    endtask

    initial begin
        int kinds;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: x tilts, all eight gestures, timeout edges
        queue_sample(fixed_sample(127, 0, 0, 0));
        queue_sample(fixed_sample(0, -128, -128, 0));
        queue_sample(fixed_sample(0, 0, 0, 3000));
        queue_sample(fixed_sample(0, 0, 0, 1));
        queue_sample(fixed_sample(-128, 0, 0, 0));
        queue_sample(fixed_sample(0, 0, 0, 4095));
        queue_sample(fixed_sample(0, 0, 0, 4095));
        queue_sample(fixed_sample(0, 0, -11, 5));
        queue_sample(fixed_sample(0, 10, 0, 5));
        queue_sample(fixed_sample(0, 11, 0, 5));
        queue_sample(fixed_sample(0, 0, 11, 0));
        queue_sample(fixed_sample(0, -11, 0, 0));
        queue_sample(fixed_sample(0, 0, -50, 7));
        queue_sample(fixed_sample(0, -50, 0, 7));
        queue_sample(fixed_sample(0, 0, 50, 7));
        queue_sample(fixed_sample(0, 50, 0, 7));
        queue_sample(fixed_sample(0, -128, -128, 9));
        queue_sample(fixed_sample(0, -20, 0, 9));
        queue_sample(fixed_sample(0, 0, 127, 9));
        queue_sample(fixed_sample(0, 127, -128, 2));
        queue_sample(fixed_sample(-10, 127, 0, 2));
        queue_sample(fixed_sample(10, 0, 127, 2));
        queue_sample(fixed_sample(-1, -1, -1, 4095));
        queue_sample(fixed_sample(0, 0, 0, 0));
        wait_drained();

        write_reg(CFG_UNUSED, 16'hFFFF);
        run_phase(10, -10, 3000, 300, 1'b0);
        run_phase(40, -40, 200, 250, 1'b0);
        run_phase(-5, 5, 1500, 200, 1'b0);
        // no tilt possible and the timer saturates against the largest limit
        run_phase(127, -128, 65535, 40, 1'b0);
        run_phase(0, 0, 1000, 250, 1'b0);
        run_phase(20, -20, 0, 200, 1'b1);
        run_phase(-128, 127, 4095, 200, 1'b0);
        run_phase($urandom_range(60, 0), -$urandom_range(60, 0),
                  $urandom_range(8000, 0), 200, 1'b0);
        wait_drained();

        if (gestures_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                gestures_due.size()));
        kinds = 0;
        foreach (gesture_hits[i]) if (gesture_hits[i] > 0) kinds++;
        $display("covered %0d samples over %0d threshold settings (%0d register writes)",
            n_samples, n_settings, n_reg_writes);
        $display("saw %0d of 8 gesture kinds, %0d timeouts, %0d stalled input cycles",
            kinds, n_timeouts, n_backpressure);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("run timed out");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== two_stage_tilt_gesture_recognizer.f =====
rtl/tgr_pkg.sv
rtl/tgr_step.sv
rtl/two_stage_tilt_gesture_recognizer.sv
sim/tb_top.sv
